### src/acsp_pkg.sv
// ----------------------------------------------------------------------------
// acsp_pkg
// Shared types and constants of the clip sample player.
// ----------------------------------------------------------------------------
package acsp_pkg;

  localparam int unsigned SrcDepth   = 65536;
  localparam int unsigned AddrW      = $clog2(SrcDepth);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned DvdW       = 36;
  localparam int unsigned DivStages  = DvdW;
  localparam int unsigned FadeSteps  = 16;
  localparam int unsigned FifoDepth  = 2;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [14:0] RateMin     = 15'd1024;
  localparam logic [14:0] RateMax     = 15'd16384;
  localparam logic [14:0] RateUnityLo = 15'd4092;
  localparam logic [14:0] RateUnityHi = 15'd4100;
  localparam logic [15:0] GainMax     = 16'd32768;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_RENDER = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLIP_START   = 3'd0,
    CFG_CLIP_LENGTH  = 3'd1,
    CFG_CLIP_OFFSET  = 3'd2,
    CFG_FADE_IN_LEN  = 3'd3,
    CFG_FADE_OUT_LEN = 3'd4,
    CFG_GAIN_Q14     = 3'd5,
    CFG_RATE_Q12     = 3'd6,
    CFG_MODE_FLAGS   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_RENDER = 2'd1,
    KIND_ZERO   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        load_index;
    logic signed [15:0] load_sample;
    logic [31:0]        timeline_pos;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic               active;
  } out_t;

  typedef struct packed {
    logic [31:0] clip_start;
    logic [31:0] clip_length;
    logic [31:0] clip_offset;
    logic [31:0] fade_in_len;
    logic [31:0] fade_out_len;
    logic [15:0] gain_q14;
    logic [14:0] rate_q12;
    logic [1:0]  mode_flags;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [AddrW-1:0]   load_index;
    logic signed [15:0] load_sample;
    logic [31:0]        pin;
    logic [CntW-1:0]    cnt;
    logic               silent;
  } item_t;

endpackage

### src/acsp_ram.sv
// ----------------------------------------------------------------------------
// acsp_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module acsp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

### src/acsp_front.sv
// ----------------------------------------------------------------------------
// acsp_front
// Accepts requests, tracks the source length and classifies renders.
// ----------------------------------------------------------------------------
module acsp_front import acsp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_data_i,
  input  cfg_t  cfg_i,
  input  logic  full_i,
  output logic  push_o,
  output item_t item_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic [32:0]     end_pos;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;
  assign push_o     = accept;
  assign end_pos    = {1'b0, cfg_i.clip_start} + {1'b0, cfg_i.clip_length};

  always_comb begin
    cnt_d              = cnt_q;
    item_o.kind        = KIND_ZERO;
    item_o.load_index  = in_data_i.load_index;
    item_o.load_sample = in_data_i.load_sample;
    item_o.pin         = in_data_i.timeline_pos - cfg_i.clip_start;
    item_o.cnt         = cnt_q;
    item_o.silent      = 1'b1;
    unique case (req_e'(in_data_i.req_type))
      REQ_LOAD: begin
        item_o.kind = KIND_LOAD;
        if (accept && ({1'b0, in_data_i.load_index} >= cnt_q)) begin
          cnt_d = {1'b0, in_data_i.load_index} + CntW'(1);
        end
      end
      REQ_RENDER: begin
        item_o.kind   = KIND_RENDER;
        item_o.silent = ~cfg_i.mode_flags[0] || (cnt_q == '0) ||
                        (in_data_i.timeline_pos < cfg_i.clip_start) ||
                        ({1'b0, in_data_i.timeline_pos} >= end_pos);
      end
      REQ_CLEAR: begin
        if (accept) begin
          cnt_d = '0;
        end
      end
      REQ_NONE: begin
        item_o.kind = KIND_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

### src/acsp_fifo.sv
// ----------------------------------------------------------------------------
// acsp_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module acsp_fifo import acsp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  input  logic  pop_i,
  output item_t data_o,
  output logic  full_o,
  output logic  valid_o
);

  item_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (FifoPtrW+1)'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + FifoPtrW'(1);
      end
      cnt_q <= cnt_q + (FifoPtrW+1)'(push_i) - (FifoPtrW+1)'(pop_i);
    end
  end

endmodule

### src/acsp_back.sv
// ----------------------------------------------------------------------------
// acsp_back
// Render pipeline: read position, modulo and fade dividers, sample memory,
// interpolation, gain, fades and saturation.
// ----------------------------------------------------------------------------
module acsp_back import acsp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_valid_i,
  input  item_t item_i,
  output logic  q_pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_data_o
);

  typedef struct packed {
    kind_e              kind;
    logic [AddrW-1:0]   ld_idx;
    logic signed [15:0] ld_smp;
    logic               silent;
    logic [CntW-1:0]    cnt;
    logic [32:0]        sp;
    logic               unity;
    logic               fi_act;
    logic               fo_act;
    logic [31:0]        fi_num;
    logic [31:0]        fo_num;
  } a_t;

  typedef struct packed {
    kind_e              kind;
    logic [AddrW-1:0]   ld_idx;
    logic signed [15:0] ld_smp;
    logic               silent;
    logic [CntW-1:0]    cnt;
    logic               unity;
    logic [11:0]        frac;
    logic [DvdW-1:0]    dvd;
    logic [CntW-1:0]    rem;
    logic               fi_act;
    logic               fo_act;
    logic [31:0]        fi_r;
    logic [31:0]        fo_r;
    logic [15:0]        fi_q;
    logic [15:0]        fo_q;
  } dv_t;

  typedef struct packed {
    logic               act;
    logic [11:0]        frac;
    logic               fi_act;
    logic               fo_act;
    logic [15:0]        fi_q;
    logic [15:0]        fo_q;
  } c_t;

  typedef struct packed {
    logic               act;
    logic               fi_act;
    logic               fo_act;
    logic [15:0]        fi_q;
    logic [15:0]        fo_q;
    logic signed [43:0] y;
  } p_t;

  function automatic logic signed [60:0] rnd(input logic signed [60:0] v,
                                             input int unsigned n);
    logic [60:0] m;
    logic [60:0] r;
    m = v[60] ? (61'(~v) + 61'd1) : 61'(v);
    r = (m + (61'd1 << (n - 1))) >> n;
    return v[60] ? $signed(~r + 61'd1) : $signed(r);
  endfunction

  logic               en;
  logic [14:0]        rate_c;
  logic [15:0]        gain_c;
  logic               loop;

  logic               va_q;
  a_t                 a_q, a_d;
  logic [DivStages:0] vdv_q;
  dv_t                dv_q [DivStages+1];
  dv_t                dv_n [DivStages+1];
  logic [47:0]        rp;
  logic               vc_q, vd_q, ve_q, vf_q, vg_q;
  c_t                 c_q, c_d;
  p_t                 d_q, d_d, e_q, e_d, f_q, f_d, g_q, g_d;
  logic [CntW-1:0]    a0, a1;
  logic [15:0]        rd_a, rd_b;
  logic signed [13:0] w0, w1;
  logic signed [29:0] pr0, pr1;
  logic signed [60:0] fade_pr, fout_pr, r_full;
  logic               out_valid_q;
  out_t               out_q, out_d;

  assign en          = ~out_valid_q | out_ready_i;
  assign q_pop_o     = en & q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign loop        = cfg_i.mode_flags[1];

  always_comb begin
    if (cfg_i.rate_q12 < RateMin) begin
      rate_c = RateMin;
    end else if (cfg_i.rate_q12 > RateMax) begin
      rate_c = RateMax;
    end else begin
      rate_c = cfg_i.rate_q12;
    end
    gain_c = (cfg_i.gain_q14 > GainMax) ? GainMax : cfg_i.gain_q14;
  end

  always_comb begin
    a_d.kind   = item_i.kind;
    a_d.ld_idx = item_i.load_index;
    a_d.ld_smp = item_i.load_sample;
    a_d.silent = item_i.silent;
    a_d.cnt    = item_i.cnt;
    a_d.sp     = {1'b0, item_i.pin} + {1'b0, cfg_i.clip_offset};
    a_d.unity  = (rate_c >= RateUnityLo) && (rate_c <= RateUnityHi);
    a_d.fi_act = (cfg_i.fade_in_len != '0) && (item_i.pin < cfg_i.fade_in_len);
    a_d.fo_act = (cfg_i.fade_out_len != '0) &&
                 (({1'b0, item_i.pin} + {1'b0, cfg_i.fade_out_len}) >
                  {1'b0, cfg_i.clip_length});
    a_d.fi_num = item_i.pin;
    a_d.fo_num = cfg_i.clip_length - item_i.pin;
  end

  assign rp = 48'(a_q.sp) * 48'(rate_c);

  always_comb begin
    dv_n[0].kind   = a_q.kind;
    dv_n[0].ld_idx = a_q.ld_idx;
    dv_n[0].ld_smp = a_q.ld_smp;
    dv_n[0].silent = a_q.silent;
    dv_n[0].cnt    = a_q.cnt;
    dv_n[0].unity  = a_q.unity;
    dv_n[0].frac   = a_q.unity ? 12'd0 : rp[11:0];
    dv_n[0].dvd    = a_q.unity ? DvdW'(a_q.sp) : rp[47:12];
    dv_n[0].rem    = '0;
    dv_n[0].fi_act = a_q.fi_act;
    dv_n[0].fo_act = a_q.fo_act;
    dv_n[0].fi_r   = a_q.fi_num;
    dv_n[0].fo_r   = a_q.fo_num;
    dv_n[0].fi_q   = '0;
    dv_n[0].fo_q   = '0;
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    logic [CntW:0] r;
    logic [32:0]   ti, to;
    always_comb begin
      dv_n[k+1] = dv_q[k];
      r = {dv_q[k].rem, dv_q[k].dvd[DvdW-1-k]};
      if (r >= {1'b0, dv_q[k].cnt}) begin
        r = r - {1'b0, dv_q[k].cnt};
      end
      dv_n[k+1].rem = r[CntW-1:0];
      ti = {dv_q[k].fi_r, 1'b0};
      to = {dv_q[k].fo_r, 1'b0};
      if (k < FadeSteps) begin
        if (ti >= {1'b0, cfg_i.fade_in_len}) begin
          ti = ti - {1'b0, cfg_i.fade_in_len};
          dv_n[k+1].fi_q = {dv_q[k].fi_q[14:0], 1'b1};
        end else begin
          dv_n[k+1].fi_q = {dv_q[k].fi_q[14:0], 1'b0};
        end
        if (to >= {1'b0, cfg_i.fade_out_len}) begin
          to = to - {1'b0, cfg_i.fade_out_len};
          dv_n[k+1].fo_q = {dv_q[k].fo_q[14:0], 1'b1};
        end else begin
          dv_n[k+1].fo_q = {dv_q[k].fo_q[14:0], 1'b0};
        end
        dv_n[k+1].fi_r = ti[31:0];
        dv_n[k+1].fo_r = to[31:0];
      end
    end
  end

  always_comb begin
    dv_t s;
    s = dv_q[DivStages];
    c_d.act    = (s.kind == KIND_RENDER) && !s.silent;
    c_d.frac   = s.frac;
    c_d.fi_act = s.fi_act;
    c_d.fo_act = s.fo_act;
    c_d.fi_q   = s.fi_q;
    c_d.fo_q   = s.fo_q;
    if (s.unity) begin
      if (loop) begin
        a0 = s.rem;
      end else begin
        a0 = s.dvd[CntW-1:0];
        if (s.dvd >= DvdW'(s.cnt)) begin
          c_d.act = 1'b0;
        end
      end
      a1 = a0;
    end else if (loop) begin
      a0 = s.rem;
      a1 = ({1'b0, s.rem} + (CntW+1)'(1) == {1'b0, s.cnt}) ? '0 :
           s.rem + CntW'(1);
    end else begin
      a0 = (s.dvd >= DvdW'(s.cnt)) ? s.cnt - CntW'(1) : s.dvd[CntW-1:0];
      a1 = (s.dvd >= DvdW'(s.cnt - CntW'(1))) ? s.cnt - CntW'(1) :
           s.dvd[CntW-1:0] + CntW'(1);
    end
  end

  acsp_ram #(
    .Width(16),
    .Depth(SrcDepth)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (en & vdv_q[DivStages] & (dv_q[DivStages].kind == KIND_LOAD)),
    .waddr_i   (dv_q[DivStages].ld_idx),
    .wdata_i   (dv_q[DivStages].ld_smp),
    .re_i      (en),
    .raddr_a_i (a0[AddrW-1:0]),
    .raddr_b_i (a1[AddrW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    w0     = $signed({1'b0, 13'(13'd4096 - {1'b0, c_q.frac})});
    w1     = $signed({2'b0, c_q.frac});
    pr0    = $signed(rd_a) * w0;
    pr1    = $signed(rd_b) * w1;
    d_d.act    = c_q.act;
    d_d.fi_act = c_q.fi_act;
    d_d.fo_act = c_q.fo_act;
    d_d.fi_q   = c_q.fi_q;
    d_d.fo_q   = c_q.fo_q;
    d_d.y      = 44'(pr0) + 44'(pr1);
  end

  always_comb begin
    e_d   = d_q;
    e_d.y = 44'(d_q.y * $signed({1'b0, gain_c}));
  end

  always_comb begin
    f_d     = e_q;
    fade_pr = 61'(e_q.y) * $signed({1'b0, e_q.fi_q});
    if (e_q.fi_act) begin
      f_d.y = 44'(rnd(fade_pr, 16));
    end
  end

  always_comb begin
    g_d     = f_q;
    fout_pr = 61'(f_q.y) * $signed({1'b0, f_q.fo_q});
    if (f_q.fo_act) begin
      g_d.y = 44'(rnd(fout_pr, 16));
    end
  end

  always_comb begin
    r_full = rnd(61'(g_q.y), 26);
    out_d.active = g_q.act;
    if (!g_q.act) begin
      out_d.out_sample = '0;
    end else if (r_full > 61'sd32767) begin
      out_d.out_sample = 16'sh7FFF;
    end else if (r_full < -61'sd32768) begin
      out_d.out_sample = 16'sh8000;
    end else begin
      out_d.out_sample = r_full[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      for (int i = 0; i <= DivStages; i++) begin
        dv_q[i] <= dv_n[i];
      end
      c_q   <= c_d;
      d_q   <= d_d;
      e_q   <= e_d;
      f_q   <= f_d;
      g_q   <= g_d;
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vdv_q       <= '0;
      vc_q        <= 1'b0;
      vd_q        <= 1'b0;
      ve_q        <= 1'b0;
      vf_q        <= 1'b0;
      vg_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      va_q        <= q_valid_i;
      vdv_q       <= {vdv_q[DivStages-1:0], va_q};
      vc_q        <= vdv_q[DivStages];
      vd_q        <= vc_q;
      ve_q        <= vd_q;
      vf_q        <= ve_q;
      vg_q        <= vf_q;
      out_valid_q <= vg_q;
    end
  end

endmodule

### src/audio_clip_sample_player_unit.sv
// ----------------------------------------------------------------------------
// audio_clip_sample_player_unit
// Mono clip player: sample loads, length clears and rendering of one output
// sample per timeline position with rate, interpolation, gain and fades.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_ready_o with an in_t payload; every
//   request yields exactly one result on out_valid_o/out_ready_i (zero for
//   loads, clears and silence). Registers are written through cfg_we_i,
//   cfg_index_i and cfg_wdata_i while no request is in flight.
//   Throughput is one request per cycle while the receiver does not stall;
//   the pipeline length is set by the 36-step modulo divider, which also
//   carries the 16-step fade dividers.
//   Loads write the sample memory in request order at the memory stage, so
//   renders see every earlier load.
//   Reset clears the source length, the registers to their defaults and all
//   pipeline valid bits; the sample memory keeps its contents.
//   When the receiver stalls the whole back pipeline holds; the two-entry
//   request queue keeps accepting until full, then in_ready_o drops.
// ----------------------------------------------------------------------------
module audio_clip_sample_player_unit import acsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t  cfg_q, cfg_d;
  logic  push, pop, full, q_valid;
  item_t item_in, item_out;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CLIP_START:   cfg_d.clip_start   = cfg_wdata_i;
        CFG_CLIP_LENGTH:  cfg_d.clip_length  = cfg_wdata_i;
        CFG_CLIP_OFFSET:  cfg_d.clip_offset  = cfg_wdata_i;
        CFG_FADE_IN_LEN:  cfg_d.fade_in_len  = cfg_wdata_i;
        CFG_FADE_OUT_LEN: cfg_d.fade_out_len = cfg_wdata_i;
        CFG_GAIN_Q14:     cfg_d.gain_q14     = cfg_wdata_i[15:0];
        CFG_RATE_Q12:     cfg_d.rate_q12     = cfg_wdata_i[14:0];
        CFG_MODE_FLAGS:   cfg_d.mode_flags   = cfg_wdata_i[1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_start   <= '0;
      cfg_q.clip_length  <= '0;
      cfg_q.clip_offset  <= '0;
      cfg_q.fade_in_len  <= '0;
      cfg_q.fade_out_len <= '0;
      cfg_q.gain_q14     <= 16'd16384;
      cfg_q.rate_q12     <= 15'd4096;
      cfg_q.mode_flags   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  acsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .full_i     (full),
    .push_o     (push),
    .item_o     (item_in)
  );

  acsp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item_in),
    .pop_i   (pop),
    .data_o  (item_out),
    .full_o  (full),
    .valid_o (q_valid)
  );

  acsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .item_i      (item_out),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the clip sample player. A scoreboard class predicts
// every result from its own copy of the sample memory and registers and checks
// results in order. Stimulus is a directed part followed by random phases over
// many register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import acsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Phases     = 12;
  localparam int unsigned PhaseItems = 130;
  localparam int unsigned AppendCap  = 64;

  class clip_scoreboard;
    logic signed [15:0] samples [SrcDepth];
    int unsigned        count;
    logic [31:0]        r_start, r_len, r_offset, r_fin, r_fout;
    logic [15:0]        r_gain;
    logic [14:0]        r_rate;
    logic [1:0]         r_mode;
    out_t               expected_q[$];
    int                 errors, n_load, n_render, n_active;

    function new();
      count = 0; r_start = 0; r_len = 0; r_offset = 0; r_fin = 0; r_fout = 0;
      r_gain = 16'd16384; r_rate = 15'd4096; r_mode = 2'd0;
      errors = 0; n_load = 0; n_render = 0; n_active = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] v);
      case (idx)
        CFG_CLIP_START:   r_start  = v;
        CFG_CLIP_LENGTH:  r_len    = v;
        CFG_CLIP_OFFSET:  r_offset = v;
        CFG_FADE_IN_LEN:  r_fin    = v;
        CFG_FADE_OUT_LEN: r_fout   = v;
        CFG_GAIN_Q14:     r_gain   = v[15:0];
        CFG_RATE_Q12:     r_rate   = v[14:0];
        CFG_MODE_FLAGS:   r_mode   = v[1:0];
        default: ;
      endcase
    endfunction

    function longint round_off(longint v, int n);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : longint'(v);
      m = (m + (64'd1 << (n - 1))) >> n;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function out_t render_at(logic [31:0] pos);
      longint unsigned start, len, pin, sp, cnt, rp, i0, i1, q;
      longint          x, y, frac, r;
      int unsigned     rate, gain;
      bit              lp;
      out_t            o;
      o = '0;
      start = r_start; len = r_len; cnt = count;
      lp = r_mode[1];
      if (!r_mode[0] || cnt == 0 || pos < start || longint'(pos) >= start + len) return o;
      pin = pos - start;
      sp = pin + r_offset;
      rate = r_rate; gain = r_gain;
      if (rate < RateMin) rate = RateMin;
      if (rate > RateMax) rate = RateMax;
      if (gain > GainMax) gain = GainMax;
      if (rate >= RateUnityLo && rate <= RateUnityHi) begin
        if (lp) sp = sp % cnt;
        else if (sp >= cnt) return o;
        x = longint'(samples[sp[15:0]]) * 4096;
      end else begin
        rp = sp * rate;
        i0 = rp >> 12;
        i1 = i0 + 1;
        frac = longint'(rp & 64'd4095);
        if (lp) begin
          i0 = i0 % cnt; i1 = i1 % cnt;
        end else begin
          if (i0 > cnt - 1) i0 = cnt - 1;
          if (i1 > cnt - 1) i1 = cnt - 1;
        end
        x = longint'(samples[i0[15:0]]) * (4096 - frac) + longint'(samples[i1[15:0]]) * frac;
      end
      y = x * longint'(gain);
      if (r_fin > 0 && pin < r_fin) begin
        q = (pin << 16) / r_fin;
        y = round_off(y * longint'(q), 16);
      end
      if (r_fout > 0 && longint'(pin) > longint'(len) - longint'(r_fout)) begin
        q = ((len - pin) << 16) / r_fout;
        y = round_off(y * longint'(q), 16);
      end
      r = round_off(y, 26);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      o.out_sample = r[15:0];
      o.active = 1'b1;
      return o;
    endfunction

    function void note(in_t req);
      out_t o;
      o = '0;
      case (req_e'(req.req_type))
        REQ_LOAD: begin
          samples[req.load_index] = req.load_sample;
          if (req.load_index + 32'd1 > count) count = req.load_index + 32'd1;
          n_load++;
        end
        REQ_RENDER: begin
          o = render_at(req.timeline_pos);
          n_render++;
          if (o.active) n_active++;
        end
        REQ_CLEAR: count = 0;
        default: ;
      endcase
      expected_q.push_back(o);
    endfunction

    function void check(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.out_sample !== e.out_sample) begin
        $display("%0t: out_sample expected %0d actual %0d", $time, e.out_sample,
                 got.out_sample);
        errors++;
      end
      if (got.active !== e.active) begin
        $display("%0t: active expected %0b actual %0b", $time, e.active, got.active);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  clip_scoreboard sb = new();
  int unsigned    send_idle, recv_idle, cycles;
  bit             written [SrcDepth];
  int unsigned    prefix, gen_cnt;

  audio_clip_sample_player_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
    if (rst_ni && in_valid_i && in_ready_o) sb.note(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check(out_data_o);
  end

  task automatic send_req(in_t req);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_regs(logic [31:0] v [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_wdata_i <= v[i];
      sb.set_reg(cfg_idx_e'(i), v[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_t load_req(logic [15:0] idx, logic [15:0] val);
    in_t r;
    r = '0;
    r.req_type = REQ_LOAD;
    r.load_index = idx;
    r.load_sample = val;
    r.timeline_pos = $urandom;
    written[idx] = 1'b1;
    while (prefix < SrcDepth && written[prefix]) prefix++;
    if (idx + 1 > gen_cnt) gen_cnt = idx + 1;
    return r;
  endfunction

  function automatic in_t other_req(req_e kind, logic [31:0] pos);
    in_t r;
    r.req_type = kind;
    r.load_index = $urandom;
    r.load_sample = $urandom;
    r.timeline_pos = pos;
    // hold off renders that could read a never-written entry
    if (kind == REQ_RENDER && gen_cnt > prefix) r.req_type = REQ_CLEAR;
    if (r.req_type == REQ_CLEAR) gen_cnt = 0;
    return r;
  endfunction

  function automatic in_t random_req();
    int unsigned pick, span;
    logic [31:0] pos;
    pick = $urandom_range(99);
    if (pick < 27) begin
      if (prefix < AppendCap && $urandom_range(1)) return load_req(prefix, $urandom);
      return load_req($urandom_range(prefix - 1), $urandom);
    end
    if (pick < 29) return load_req($urandom, $urandom);
    if (pick < 33) return other_req(REQ_CLEAR, $urandom);
    if (pick < 36) return other_req(REQ_NONE, $urandom);
    span = (sb.r_len > 400) ? 400 : sb.r_len;
    if ($urandom_range(99) < 85) pos = sb.r_start + $urandom_range(span + 8) - 4;
    else pos = $urandom;
    return other_req(REQ_RENDER, pos);
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(4))
      0: return 0;
      1: return 16384;
      2: return 32768;
      3: return 16'hFFFF;
      default: return $urandom_range(16'hFFFF);
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(7))
      0: return 1024;
      1: return 16384;
      2: return 4096;
      3: return 4092;
      4: return 4100;
      5: return 4091;
      6: return 4101;
      default: return $urandom_range(15'h7FFF);
    endcase
  endfunction

  initial begin
    logic [31:0] regs [8];
    logic [1:0]  modes [4];
    int unsigned dir_start;
    modes = '{2'd3, 2'd1, 2'd0, 2'd2};
    rst_ni = 1'b0;
    cycles = 0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    out_ready_i <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_wdata_i <= '0;
    send_idle = 34;
    recv_idle = 70;
    prefix = 0;
    gen_cnt = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_start = 100;
    regs = '{dir_start, 50, 0, 10, 10, 32768, 4096, 1};
    write_regs(regs);
    send_req(load_req(0, 16'h8000));
    send_req(load_req(1, 16'h7FFF));
    send_req(load_req(2, 16'h0000));
    send_req(load_req(3, 16'hFFFF));
    send_req(load_req(4, 16'h5555));
    send_req(load_req(5, 16'hAAAA));
    for (int i = 6; i < 10; i++) send_req(load_req(i, $urandom));
    send_req(other_req(REQ_RENDER, dir_start - 1));
    send_req(other_req(REQ_RENDER, dir_start));
    send_req(other_req(REQ_RENDER, dir_start + 1));
    send_req(other_req(REQ_RENDER, dir_start + 5));
    send_req(other_req(REQ_RENDER, dir_start + 49));
    send_req(other_req(REQ_RENDER, dir_start + 50));
    send_req(other_req(REQ_RENDER, dir_start + 20));
    send_req(other_req(REQ_NONE, 32'hFFFF_FFFF));
    send_req(other_req(REQ_CLEAR, 0));
    send_req(other_req(REQ_RENDER, dir_start + 3));
    send_req(load_req(16'hFFFF, $urandom));
    send_req(other_req(REQ_CLEAR, 0));
    send_req(load_req(9, $urandom));
    send_req(other_req(REQ_RENDER, dir_start + 3));
    settle();

    for (int p = 0; p < Phases; p++) begin
      send_idle = (p < 4) ? 34 : (p < 8) ? 70 : 0;
      recv_idle = (p < 4) ? 70 : (p < 8) ? 34 : 0;
      regs[0] = (p == 0) ? 0 : (p == 1) ? 32'hFFFF_FF00 : $urandom;
      regs[1] = (p == 2) ? 0 : (p == 3) ? 32'hFFFF_FFFF : $urandom_range(400, 1);
      regs[2] = ($urandom_range(4) == 0) ? $urandom : $urandom_range(64);
      regs[3] = ($urandom_range(3) == 0) ? $urandom :
                ($urandom_range(1) ? 0 : $urandom_range(200, 1));
      regs[4] = ($urandom_range(3) == 0) ? $urandom :
                ($urandom_range(1) ? 0 : $urandom_range(200, 1));
      regs[5] = pick_gain();
      regs[6] = pick_rate();
      regs[7] = (p < 4) ? modes[p] : ($urandom_range(9) == 0 ? $urandom_range(3)
                                      : {$urandom_range(1), 1'b1});
      write_regs(regs);
      for (int n = 0; n < PhaseItems; n++) send_req(random_req());
      settle();
    end

    repeat (60) @(posedge clk_i);
    $display("Covered %0d loads and %0d renders (%0d with clip audio) over %0d settings.",
             sb.n_load, sb.n_render, sb.n_active, Phases + 1);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
